[sv/adamlr_pkg.sv]
package adamlr_pkg;

    // Sizes and field widths
    localparam int MAX_FEATURES_DEF = 1024;
    localparam int MAX_NONZERO_DEF  = 64;
    localparam int IDX_W            = 10;
    localparam int DATA_W           = 32;
    localparam int COEF_W           = 31;
    localparam int CFG_IDX_W        = 3;
    localparam int PEND_W           = IDX_W + DATA_W;

    // Input item modes
    localparam logic [1:0] MODE_FEAT  = 2'd0;
    localparam logic [1:0] MODE_EPOCH = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L2     = 3'd5;

    // Register reset values, Q1.30
    localparam logic [COEF_W-1:0] RST_STEP   = 31'd1073742;
    localparam logic [COEF_W-1:0] RST_BETA1  = 31'd107374182;
    localparam logic [COEF_W-1:0] RST_BETA2  = 31'd1073742;
    localparam logic [COEF_W-1:0] RST_EPS    = 31'd11;
    localparam logic [COEF_W-1:0] RST_LAMBDA = 31'd1073741813;
    localparam logic [COEF_W-1:0] RST_L2     = 31'd0;

    localparam logic [COEF_W-1:0] ONE30 = 31'h4000_0000;
    localparam logic [COEF_W-1:0] MAX31 = 31'h7FFF_FFFF;

    // exp(-2^-24) in Q.62 and its repeated squares, one per bit of |z|
    localparam int          POW_BITS = 29;
    localparam logic [63:0] POW_BASE = 64'h3FFF_FFC0_0000_2000;

    typedef logic [63:0] t_pow_tab [POW_BITS];

    function automatic logic [63:0] f_mul62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, mid;
        ah  = a >> 31;
        al  = a & 64'h7FFF_FFFF;
        bh  = b >> 31;
        bl  = b & 64'h7FFF_FFFF;
        mid = ah * bl + al * bh + ((al * bl) >> 31);
        return ah * bh + (mid >> 31);
    endfunction

    function automatic t_pow_tab f_pow_table();
        t_pow_tab    tab;
        logic [63:0] t;
        t = POW_BASE;
        for (int j = 0; j < POW_BITS; j++) begin
            tab[j] = t;
            t      = f_mul62(t, t);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = f_pow_table();

endpackage

[sv/adam_logistic_regression_trainer_top.sv]
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall i_mode, i_feature_index, i_feature_value,
//                                              i_label_bit, i_sample_last
// result    out        o_out_valid / i_out_stall o_result_value, o_overflow_flag
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// A feature item that is not a sample's last keeps the sequencer idle; an epoch-end
// item and a weight read hold o_in_stall while they run, and a sample's last item while
// its dot product, sigmoid and per-entry updates run on the single shared multiplier
// and the one-bit-a-cycle divide and two-bits-a-cycle root unit (no exp product when
// |z| >= 2^29). After reset the weight and moment memories are cleared address by
// address, with o_in_stall high. A held result stalls the next result item only.
module adam_logistic_regression_trainer_top #(
    parameter int MAX_FEATURES = adamlr_pkg::MAX_FEATURES_DEF,
    parameter int MAX_NONZERO  = adamlr_pkg::MAX_NONZERO_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_mode,
    input  logic [adamlr_pkg::IDX_W-1:0]       i_feature_index,
    input  logic signed [adamlr_pkg::DATA_W-1:0] i_feature_value,
    input  logic                               i_label_bit,
    input  logic                               i_sample_last,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [adamlr_pkg::DATA_W-1:0] o_result_value,
    output logic                               o_overflow_flag,
    input  logic                               i_cfg_we,
    input  logic [adamlr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adamlr_pkg::COEF_W-1:0]      i_cfg_data
);
    import adamlr_pkg::*;

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
    localparam int CW = $clog2(MAX_NONZERO + 1);
    localparam int ZW = 48;

    localparam logic signed [65:0] RND23   = 66'sd8388608;
    localparam logic signed [65:0] RND29   = 66'sd536870912;
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic [63:0]        ONE62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0]        ONE54   = 64'h0040_0000_0000_0000;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_EP0, S_EP1, S_EP2, S_EP3, S_RD0, S_RD1,
        S_P0, S_P1, S_P2, S_P3, S_D_RDP, S_D_LDP, S_D_RDF, S_D_MUL, S_D_ACC,
        S_SG0, S_SGL, S_M0, S_M1, S_M2, S_M3, S_M4, S_SGE, S_SGD,
        S_U_RDP, S_U_LDP, S_U_RDF, S_U_LDF, S_U_ERRX, S_U_GRAD, S_U_M1, S_U_M2,
        S_U_MW, S_U_G2, S_U_V1, S_U_V2, S_U_VW, S_U_HM, S_U_HV, S_U_DEN, S_U_SD,
        S_U_WW, S_DIV, S_SQRT, S_FIN
    } t_state;

    t_state r_state, r_ret;

    logic [COEF_W-1:0] r_alpha, r_beta1, r_beta2, r_eps, r_lambda, r_l2;
    logic [COEF_W-1:0] r_lam_pow, r_b1_pow, r_b2_pow;
    logic [COEF_W-1:0] r_tbeta, r_c1, r_c2, r_hm, r_vnew, r_g2;
    logic [CW-1:0]     r_count, r_k;
    logic              r_ovf, r_label, r_zneg, r_rdok;
    logic [AW-1:0]     r_fa;
    logic signed [31:0] r_x, r_w, r_m, r_grad, r_mnew, r_hold;
    logic              r_hold_ovf;
    logic [30:0]       r_v;
    logic signed [ZW-1:0] r_z;
    logic [POW_BITS-1:0] r_abs;
    logic [4:0]        r_j;
    logic [63:0]       r_acc62;
    logic [64:0]       r_mid;
    logic signed [25:0] r_err;
    logic signed [39:0] r_t1;
    logic signed [65:0] r_sum, r_prod;
    logic [34:0]       r_den, r_dd, r_rem;
    logic [63:0]       r_dn, r_q;
    logic [5:0]        r_it;
    logic              r_out_valid, r_res_ovf;
    logic signed [31:0] r_res;

    // Memory ports
    logic [DATA_W-1:0] rd_w, rd_m, rd_v, wd_w, wd_m, wd_v;
    logic              we_w, we_m, we_v, we_p;
    logic [PEND_W-1:0] rd_p;

    // Shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    logic in_acc, idx_ok, buffered, room;
    logic [COEF_W-1:0] omb1, omb2, q30_c, v_new_c, g2_c, hv_c, hm_c;
    logic signed [31:0] m_new_c, grad_c, w_new_c, pred_c;
    logic signed [39:0] t1_c;
    logic signed [65:0] tmp_m, tmp_g, tmp_w, tmp_t1;
    logic [65:0] tmp_v, tmp_q, tmp_g2;
    logic [32:0] mag_c;
    logic [63:0] pw;
    logic [31:0] e_c, den_s;
    logic [35:0] div_sh;
    logic [36:0] sq_sh, sq_tr;

    function automatic logic [COEF_W-1:0] f_one_minus(input logic [COEF_W-1:0] a);
        return (a >= ONE30) ? '0 : ONE30 - a;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        if (v > S32_MAX) return 32'sh7FFF_FFFF;
        if (v < S32_MIN) return -32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [COEF_W-1:0] f_clamp31(input logic [65:0] v);
        return (v > {35'd0, MAX31}) ? MAX31 : v[30:0];
    endfunction

    function automatic logic signed [32:0] f_u31(input logic [COEF_W-1:0] a);
        return {2'b00, a};
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign idx_ok   = {{(32-IDX_W){1'b0}}, i_feature_index} < 32'(MAX_FEATURES);
    assign buffered = in_acc && (i_mode == MODE_FEAT) && (i_feature_value != '0) && idx_ok;
    assign room     = r_count < CW'(MAX_NONZERO);

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_res;
    assign o_overflow_flag = r_res_ovf;

    // Datapath arithmetic on the registered product and the working registers
    always_comb begin
        omb1    = f_one_minus(r_beta1);
        omb2    = f_one_minus(r_beta2);
        tmp_q   = unsigned'(r_prod + RND29) >> 30;
        q30_c   = f_clamp31(tmp_q);
        tmp_t1  = (r_prod + RND23) >>> 24;
        t1_c    = tmp_t1[39:0];
        tmp_g   = signed'({{26{r_t1[39]}}, r_t1}) + ((r_prod + RND29) >>> 30);
        grad_c  = f_sat32(tmp_g);
        tmp_m   = (r_sum + r_prod + RND29) >>> 30;
        m_new_c = f_sat32(tmp_m);
        tmp_g2  = unsigned'(r_prod + RND23) >> 24;
        g2_c    = f_clamp31(tmp_g2);
        tmp_v   = unsigned'(r_sum + r_prod + RND29) >> 30;
        v_new_c = f_clamp31(tmp_v);
        hm_c    = f_clamp31({2'b00, r_q});
        hv_c    = hm_c;
        mag_c   = r_mnew[31] ? 33'(-{r_mnew[31], r_mnew}) : {1'b0, r_mnew};
        tmp_w   = r_mnew[31] ? ({{34{r_w[31]}}, r_w} + signed'({2'b00, r_q}))
                             : ({{34{r_w[31]}}, r_w} - signed'({2'b00, r_q}));
        w_new_c = f_sat32(tmp_w);
        pw      = POW_TAB[r_j];
        e_c     = 32'((r_acc62 + 64'h8000_0000) >> 32);
        den_s   = 32'h4000_0000 + e_c;
        pred_c  = r_zneg ? (32'sh0100_0000 - signed'({7'd0, r_q[24:0]}))
                         : signed'({7'd0, r_q[24:0]});
        div_sh  = {r_rem, r_dn[63]};
        sq_sh   = {r_rem, r_dn[63:62]};
        sq_tr   = {3'd0, r_q[31:0], 2'b01};
    end

    // Select the operands of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_EP0:    begin mul_a = f_u31(r_lam_pow); mul_b = f_u31(r_lambda); end
            S_EP1:    begin mul_a = f_u31(r_b1_pow);  mul_b = f_u31(omb1);     end
            S_EP2:    begin mul_a = f_u31(r_b2_pow);  mul_b = f_u31(omb2);     end
            S_P0:     begin mul_a = f_u31(omb1);      mul_b = f_u31(r_lam_pow); end
            S_P1:     begin mul_a = f_u31(omb1);      mul_b = f_u31(r_b1_pow); end
            S_P2:     begin mul_a = f_u31(omb2);      mul_b = f_u31(r_b2_pow); end
            S_D_MUL:  begin mul_a = {rd_w[31], rd_w}; mul_b = {r_x[31], r_x};  end
            S_M0:     begin mul_a = {2'b00, r_acc62[30:0]}; mul_b = {2'b00, pw[30:0]}; end
            S_M1:     begin mul_a = signed'(r_acc62[63:31]); mul_b = {2'b00, pw[30:0]}; end
            S_M2:     begin mul_a = {2'b00, r_acc62[30:0]}; mul_b = signed'(pw[63:31]); end
            S_M3:     begin mul_a = signed'(r_acc62[63:31]); mul_b = signed'(pw[63:31]); end
            S_U_LDF:  begin mul_a = {{7{r_err[25]}}, r_err}; mul_b = {r_x[31], r_x}; end
            S_U_ERRX: begin mul_a = f_u31(r_l2);      mul_b = {r_w[31], r_w};  end
            S_U_M1:   begin mul_a = f_u31(r_tbeta);   mul_b = {r_grad[31], r_grad}; end
            S_U_M2:   begin mul_a = f_u31(ONE30 - r_tbeta); mul_b = {r_m[31], r_m}; end
            S_U_MW:   begin mul_a = {r_grad[31], r_grad}; mul_b = {r_grad[31], r_grad}; end
            S_U_V1:   begin mul_a = f_u31(r_beta2);   mul_b = f_u31(r_g2);     end
            S_U_V2:   begin mul_a = f_u31(omb2);      mul_b = f_u31(r_v);      end
            S_U_DEN:  begin mul_a = f_u31(r_alpha);   mul_b = f_u31(r_hm);     end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Memory write controls
    always_comb begin
        we_w = (r_state == S_CLR) || (r_state == S_U_WW);
        we_m = (r_state == S_CLR) || (r_state == S_U_MW);
        we_v = (r_state == S_CLR) || (r_state == S_U_VW);
        wd_w = (r_state == S_CLR) ? '0 : w_new_c;
        wd_m = (r_state == S_CLR) ? '0 : m_new_c;
        wd_v = (r_state == S_CLR) ? '0 : {1'b0, v_new_c};
        we_p = buffered && room;
    end

    adamlr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FEATURES)) u_ram_w (
        .i_clk(i_clk), .i_we(we_w), .i_waddr(r_fa), .i_wdata(wd_w),
        .i_raddr(r_fa), .o_rdata(rd_w)
    );
    adamlr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FEATURES)) u_ram_m (
        .i_clk(i_clk), .i_we(we_m), .i_waddr(r_fa), .i_wdata(wd_m),
        .i_raddr(r_fa), .o_rdata(rd_m)
    );
    adamlr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FEATURES)) u_ram_v (
        .i_clk(i_clk), .i_we(we_v), .i_waddr(r_fa), .i_wdata(wd_v),
        .i_raddr(r_fa), .o_rdata(rd_v)
    );
    adamlr_ram #(.WIDTH(PEND_W), .DEPTH(MAX_NONZERO)) u_ram_p (
        .i_clk(i_clk), .i_we(we_p), .i_waddr(r_count[PW-1:0]),
        .i_wdata({i_feature_index, i_feature_value}),
        .i_raddr(r_k[PW-1:0]), .o_rdata(rd_p)
    );

    // Shared multiplier, one product a cycle
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ret       <= S_IDLE;
            r_fa        <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_lam_pow   <= ONE30;
            r_b1_pow    <= ONE30;
            r_b2_pow    <= ONE30;
            r_alpha     <= RST_STEP;
            r_beta1     <= RST_BETA1;
            r_beta2     <= RST_BETA2;
            r_eps       <= RST_EPS;
            r_lambda    <= RST_LAMBDA;
            r_l2        <= RST_L2;
        end else begin
            // Take a configuration write
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STEP:   r_alpha  <= i_cfg_data;
                    CFG_BETA1:  r_beta1  <= i_cfg_data;
                    CFG_BETA2:  r_beta2  <= i_cfg_data;
                    CFG_EPS:    r_eps    <= i_cfg_data;
                    CFG_LAMBDA: r_lambda <= i_cfg_data;
                    CFG_L2:     r_l2     <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once its transaction completes
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                // Sweep zeros through the weight and moment memories
                S_CLR: begin
                    r_fa <= r_fa + 1'b1;
                    if (r_fa == AW'(MAX_FEATURES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_fa <= AW'(i_feature_index);
                        unique case (i_mode)
                            MODE_FEAT: begin
                                if (buffered && room) begin
                                    r_count <= r_count + 1'b1;
                                end else if (buffered) begin
                                    r_ovf <= 1'b1;
                                end
                                if (i_sample_last) begin
                                    r_label <= i_label_bit;
                                    r_state <= S_P0;
                                end
                            end
                            MODE_EPOCH: r_state <= S_EP0;
                            MODE_READ: begin
                                r_rdok  <= idx_ok;
                                r_state <= S_RD0;
                            end
                            default: ;
                        endcase
                    end
                end
                // Advance the running powers
                S_EP0: r_state <= S_EP1;
                S_EP1: begin r_lam_pow <= q30_c; r_state <= S_EP2; end
                S_EP2: begin r_b1_pow  <= q30_c; r_state <= S_EP3; end
                S_EP3: begin r_b2_pow  <= q30_c; r_state <= S_IDLE; end
                // Weight read
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_hold     <= r_rdok ? signed'(rd_w) : '0;
                    r_hold_ovf <= 1'b0;
                    r_state    <= S_FIN;
                end
                // Per-sample coefficients
                S_P0: begin r_z <= '0; r_state <= S_P1; end
                S_P1: begin r_tbeta <= f_one_minus(q30_c); r_state <= S_P2; end
                S_P2: begin
                    r_c1    <= (f_one_minus(q30_c) == '0) ? 31'd1 : f_one_minus(q30_c);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_c2    <= (f_one_minus(q30_c) == '0) ? 31'd1 : f_one_minus(q30_c);
                    r_k     <= '0;
                    r_state <= (r_count == '0) ? S_SG0 : S_D_RDP;
                end
                // Dot product over the buffered entries
                S_D_RDP: r_state <= S_D_LDP;
                S_D_LDP: begin
                    r_fa    <= AW'(rd_p[PEND_W-1:DATA_W]);
                    r_x     <= rd_p[DATA_W-1:0];
                    r_state <= S_D_RDF;
                end
                S_D_RDF: r_state <= S_D_MUL;
                S_D_MUL: r_state <= S_D_ACC;
                S_D_ACC: begin
                    r_z <= r_z + tmp_t1[ZW-1:0];
                    if (CW'(r_k + 1'b1) == r_count) begin
                        r_state <= S_SG0;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_D_RDP;
                    end
                end
                // Sigmoid: exp(-|z|) as a product of table powers
                S_SG0: begin
                    r_zneg  <= r_z[ZW-1];
                    r_abs   <= r_z[ZW-1] ? POW_BITS'(-r_z) : r_z[POW_BITS-1:0];
                    r_j     <= '0;
                    if ((r_z[ZW-1] ? -r_z : r_z) >= (ZW'(1) <<< POW_BITS)) begin
                        r_acc62 <= '0;
                        r_state <= S_SGE;
                    end else begin
                        r_acc62 <= ONE62;
                        r_state <= S_SGL;
                    end
                end
                S_SGL: begin
                    if (r_j == 5'(POW_BITS)) begin
                        r_state <= S_SGE;
                    end else if (r_abs[r_j]) begin
                        r_state <= S_M0;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin r_mid <= 65'(unsigned'(r_prod) >> 31); r_state <= S_M2; end
                S_M2: begin r_mid <= r_mid + 65'(unsigned'(r_prod)); r_state <= S_M3; end
                S_M3: begin r_mid <= r_mid + 65'(unsigned'(r_prod)); r_state <= S_M4; end
                S_M4: begin
                    r_acc62 <= r_prod[63:0] + r_mid[64:31];
                    r_j     <= r_j + 1'b1;
                    r_state <= S_SGL;
                end
                S_SGE: begin
                    r_dn    <= ONE54 + 64'(den_s >> 1);
                    r_dd    <= 35'(den_s);
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_ret   <= S_SGD;
                    r_state <= S_DIV;
                end
                S_SGD: begin
                    r_hold     <= pred_c;
                    r_hold_ovf <= r_ovf;
                    r_ovf      <= 1'b0;
                    r_err      <= signed'({1'b0, pred_c[24:0]})
                                  - (r_label ? 26'sh100_0000 : 26'sd0);
                    r_k        <= '0;
                    r_state    <= (r_count == '0) ? S_FIN : S_U_RDP;
                end
                // Moment and weight update of one entry
                S_U_RDP: r_state <= S_U_LDP;
                S_U_LDP: begin
                    r_fa    <= AW'(rd_p[PEND_W-1:DATA_W]);
                    r_x     <= rd_p[DATA_W-1:0];
                    r_state <= S_U_RDF;
                end
                S_U_RDF: r_state <= S_U_LDF;
                S_U_LDF: begin
                    r_w     <= rd_w;
                    r_m     <= rd_m;
                    r_v     <= rd_v[30:0];
                    r_state <= S_U_ERRX;
                end
                S_U_ERRX: begin r_t1 <= t1_c; r_state <= S_U_GRAD; end
                S_U_GRAD: begin r_grad <= grad_c; r_state <= S_U_M1; end
                S_U_M1:   r_state <= S_U_M2;
                S_U_M2:   begin r_sum <= r_prod; r_state <= S_U_MW; end
                S_U_MW:   begin r_mnew <= m_new_c; r_state <= S_U_G2; end
                S_U_G2:   begin r_g2 <= g2_c; r_state <= S_U_V1; end
                S_U_V1:   r_state <= S_U_V2;
                S_U_V2:   begin r_sum <= r_prod; r_state <= S_U_VW; end
                S_U_VW: begin
                    r_vnew  <= v_new_c;
                    r_dn    <= {1'b0, mag_c, 30'd0} + 64'(r_c1 >> 1);
                    r_dd    <= 35'(r_c1);
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_ret   <= S_U_HM;
                    r_state <= S_DIV;
                end
                S_U_HM: begin
                    r_hm    <= hm_c;
                    r_dn    <= {3'd0, r_vnew, 30'd0} + 64'(r_c2 >> 1);
                    r_dd    <= 35'(r_c2);
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_ret   <= S_U_HV;
                    r_state <= S_DIV;
                end
                S_U_HV: begin
                    r_dn    <= {9'd0, hv_c, 24'd0};
                    r_q     <= '0;
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_ret   <= S_U_DEN;
                    r_state <= S_SQRT;
                end
                S_U_DEN: begin
                    r_den   <= (({r_q[28:0], 6'd0} + {4'd0, r_eps}) == '0) ? 35'd1
                               : ({r_q[28:0], 6'd0} + {4'd0, r_eps});
                    r_state <= S_U_SD;
                end
                S_U_SD: begin
                    r_dn    <= r_prod[63:0] + 64'(r_den >> 1);
                    r_dd    <= r_den;
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_ret   <= S_U_WW;
                    r_state <= S_DIV;
                end
                S_U_WW: begin
                    if (CW'(r_k + 1'b1) == r_count) begin
                        r_count <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_U_RDP;
                    end
                end
                // Restoring divide, one quotient bit a cycle
                S_DIV: begin
                    r_dn <= r_dn << 1;
                    if (div_sh >= {1'b0, r_dd}) begin
                        r_rem <= 35'(div_sh - {1'b0, r_dd});
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= div_sh[34:0];
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 6'd63) begin
                        r_state <= r_ret;
                    end
                end
                // Integer root, two radicand bits a cycle
                S_SQRT: begin
                    r_dn <= r_dn << 2;
                    if (sq_sh >= sq_tr) begin
                        r_rem <= 35'(sq_sh - sq_tr);
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= sq_sh[34:0];
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 6'd31) begin
                        r_state <= r_ret;
                    end
                end
                // Hand the result to the output register when it is free
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_res       <= r_hold;
                        r_res_ovf   <= r_hold_ovf;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/adamlr_ram.sv]
module adamlr_ram #(
    parameter int WIDTH = adamlr_pkg::DATA_W,
    parameter int DEPTH = adamlr_pkg::MAX_FEATURES_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/adamlr_checker.sv]
module adamlr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [1:0]                         i_mode,
    input logic [adamlr_pkg::IDX_W-1:0]       i_feature_index,
    input logic signed [adamlr_pkg::DATA_W-1:0] i_feature_value,
    input logic                               i_label_bit,
    input logic                               i_sample_last,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [adamlr_pkg::DATA_W-1:0] o_result_value,
    input logic                               o_overflow_flag,
    input logic                               i_cfg_we,
    input logic [adamlr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [adamlr_pkg::COEF_W-1:0]      i_cfg_data
);
    import adamlr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
                                       && $stable(o_overflow_flag))
        else $error("stalled result changed");

    // No result straight out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Hold off input while the memories are cleared
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // An epoch end gives no result
    a_epoch_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_mode == MODE_EPOCH) && !o_out_valid
        |=> !o_out_valid)
        else $error("epoch end produced a result");
endmodule

bind adam_logistic_regression_trainer_top adamlr_checker u_adamlr_checker (.*);

[tb/sv/tb_adam_logistic_regression_trainer_top.sv]
`timescale 1ns / 1ps

module tb_adam_logistic_regression_trainer_top;
    import adamlr_pkg::*;

    typedef longint unsigned t_u64;
    typedef longint          t_s64;

    localparam logic [1:0] MODE_NOP     = 2'd3;
    localparam int         NUM_FEAT     = 1024;
    localparam int         NUM_PEND     = 64;
    localparam int         SETTLE_CYC   = 20000;
    localparam int         CYCLE_LIMIT  = 3000000;
    localparam t_u64       Q30_ONE      = 64'd1 << 30;
    localparam t_u64       Q31_MAX      = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] val;
        logic               label;
        logic               last;
    } t_feat_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic               ovf;
    } t_pred_res;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_mode = MODE_FEAT;
    logic [IDX_W-1:0]         i_feature_index = '0;
    logic signed [DATA_W-1:0] i_feature_value = '0;
    logic                     i_label_bit = 1'b0;
    logic                     i_sample_last = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_overflow_flag;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [COEF_W-1:0]        i_cfg_data = '0;

    adam_logistic_regression_trainer_top dut (.*);

    // Shadow trainer state
    t_u64 coef [6];
    int weight_mem [NUM_FEAT];
    int mom1_mem [NUM_FEAT];
    int mom2_mem [NUM_FEAT];
    int buf_idx [NUM_PEND];
    int buf_val [NUM_PEND];
    int buf_cnt;
    bit buf_ovf;
    t_u64 lam_pow, b1_pow, b2_pow;

    t_feat_item stim_q [$];
    t_pred_res  pred_q [$];
    t_feat_item cur_item;
    int n_loaded = 0;
    int n_taken = 0;
    int n_errors = 0;
    int cycle = 0;
    bit calm;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_s64 sat32(t_s64 v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Round to nearest, halves up
    function automatic t_s64 round_shift(t_s64 v, int s);
        return (v + (t_s64'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_u64 coef_mul(t_u64 a, t_u64 b);
        t_u64 r;
        r = ((a & Q31_MAX) * (b & Q31_MAX) + (Q30_ONE >> 1)) >> 30;
        return (r > Q31_MAX) ? Q31_MAX : r;
    endfunction

    function automatic t_u64 complement(t_u64 a);
        return (a >= Q30_ONE) ? 64'd0 : Q30_ONE - a;
    endfunction

    function automatic t_u64 frac62_mul(t_u64 a, t_u64 b);
        t_u64 ah, al, bh, bl, mid;
        ah  = a >> 31;
        al  = a & Q31_MAX;
        bh  = b >> 31;
        bl  = b & Q31_MAX;
        mid = ah * bl + al * bh + ((al * bl) >> 31);
        return ah * bh + (mid >> 31);
    endfunction

    function automatic int logistic(t_s64 z);
        t_u64 a, e, acc, t, den, s;
        a = (z < 0) ? t_u64'(-z) : t_u64'(z);
        e = 0;
        if (a < (64'd1 << 29)) begin
            acc = 64'd1 << 62;
            t   = (64'd1 << 62) - (64'd1 << 38) + (64'd1 << 13);
            for (int j = 0; j < 29; j++) begin
                if (a[j]) acc = frac62_mul(acc, t);
                t = frac62_mul(t, t);
            end
            e = (acc + (64'd1 << 31)) >> 32;
        end
        den = Q30_ONE + e;
        s   = ((64'd1 << 54) + den / 2) / den;
        return (z < 0) ? int'((64'd1 << 24) - s) : int'(s);
    endfunction

    function automatic t_u64 int_root(t_u64 n);
        t_u64 r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Adam step on one buffered entry
    function automatic void adam_update(int idx, int x, t_s64 err);
        t_u64 omb1, omb2, tbeta, c1, c2, g2, v, hv, root, den, num, step;
        t_s64 w, grad, mag, hm;
        omb1  = complement(coef[CFG_BETA1]);
        omb2  = complement(coef[CFG_BETA2]);
        tbeta = complement(coef_mul(omb1, lam_pow));
        c1    = complement(coef_mul(omb1, b1_pow));
        c2    = complement(coef_mul(omb2, b2_pow));
        w     = weight_mem[idx];
        grad  = sat32(round_shift(err * t_s64'(x), 24)
                      + round_shift(t_s64'(coef[CFG_L2]) * w, 30));
        mom1_mem[idx] = int'(sat32(round_shift(t_s64'(tbeta) * grad +
                        t_s64'(Q30_ONE - tbeta) * t_s64'(mom1_mem[idx]), 30)));
        g2 = (t_u64'(grad * grad) + (64'd1 << 23)) >> 24;
        if (g2 > Q31_MAX) g2 = Q31_MAX;
        v = (coef[CFG_BETA2] * g2 + omb2 * t_u64'(mom2_mem[idx]) + (Q30_ONE >> 1)) >> 30;
        if (v > Q31_MAX) v = Q31_MAX;
        mom2_mem[idx] = int'(v);
        if (c1 == 0) c1 = 1;
        if (c2 == 0) c2 = 1;
        mag = (mom1_mem[idx] < 0) ? -t_s64'(mom1_mem[idx]) : t_s64'(mom1_mem[idx]);
        hm  = t_s64'(((t_u64'(mag) << 30) + c1 / 2) / c1);
        if (hm > t_s64'(Q31_MAX)) hm = t_s64'(Q31_MAX);
        hv = ((v << 30) + c2 / 2) / c2;
        if (hv > Q31_MAX) hv = Q31_MAX;
        root = int_root(hv << 24);
        den  = root * 64 + coef[CFG_EPS];
        if (den == 0) den = 1;
        num  = coef[CFG_STEP] * t_u64'(hm);
        step = (num + den / 2) / den;
        if (mom1_mem[idx] < 0) weight_mem[idx] = int'(sat32(w + t_s64'(step)));
        else weight_mem[idx] = int'(sat32(w - t_s64'(step)));
    endfunction

    // Advance the shadow trainer by one accepted transaction
    function automatic void train_step(t_feat_item it);
        t_s64 z, err;
        int p;
        t_pred_res r;
        case (it.mode)
            MODE_EPOCH: begin
                lam_pow = coef_mul(lam_pow, coef[CFG_LAMBDA]);
                b1_pow  = coef_mul(b1_pow, complement(coef[CFG_BETA1]));
                b2_pow  = coef_mul(b2_pow, complement(coef[CFG_BETA2]));
            end
            MODE_READ: begin
                r.value = weight_mem[it.idx];
                r.ovf   = 1'b0;
                pred_q.insert(pred_q.size(), r);
            end
            MODE_FEAT: begin
                if (it.val != 0) begin
                    if (buf_cnt < NUM_PEND) begin
                        buf_idx[buf_cnt] = it.idx;
                        buf_val[buf_cnt] = it.val;
                        buf_cnt++;
                    end else begin
                        buf_ovf = 1'b1;
                    end
                end
                if (it.last) begin
                    z = 0;
                    for (int k = 0; k < buf_cnt; k++)
                        z += round_shift(t_s64'(weight_mem[buf_idx[k]]) * t_s64'(buf_val[k]),
                                         24);
                    p   = logistic(z);
                    err = t_s64'(p) - (it.label ? t_s64'(1) <<< 24 : t_s64'(0));
                    for (int k = 0; k < buf_cnt; k++)
                        adam_update(buf_idx[k], buf_val[k], err);
                    r.value = p;
                    r.ovf   = buf_ovf;
                    pred_q.insert(pred_q.size(), r);
                    buf_cnt = 0;
                    buf_ovf = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic push_item(logic [1:0] mode, int idx, int val, bit label, bit last);
        t_feat_item it;
        it.mode  = mode;
        it.idx   = idx[IDX_W-1:0];
        it.val   = val;
        it.label = label;
        it.last  = last;
        stim_q.insert(stim_q.size(), it);
    endtask

    function automatic int rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return $urandom;
        return int'($urandom_range(0, 1 << 26)) - (1 << 25);
    endfunction

    task automatic gen_sample(int n, bit wide);
        int idx;
        for (int k = 0; k < n; k++) begin
            idx = wide ? $urandom_range(0, NUM_FEAT - 1) : $urandom_range(0, 15);
            push_item(MODE_FEAT, idx, rand_value(), $urandom_range(0, 1), k == n - 1);
        end
    endtask

    // Mostly well-formed samples, with epoch ends, reads and some noise between
    task automatic gen_random(int count, bit with_overflow);
        int made, r, n;
        made = 0;
        if (with_overflow) begin
            gen_sample(NUM_PEND + 2, 1'b1);
            made += NUM_PEND + 2;
        end
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 58) begin
                n = $urandom_range(1, 6);
                gen_sample(n, 1'b0);
                made += n;
            end else if (r < 70) begin
                push_item(MODE_EPOCH, $urandom, $urandom, $urandom_range(0, 1),
                          $urandom_range(0, 1));
                made++;
            end else if (r < 84) begin
                push_item(MODE_READ, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15),
                          $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
                made++;
            end else if (r < 90) begin
                // interrupt a sample with an epoch end or a read
                gen_sample(2, 1'b0);
                stim_q[$].last = 1'b0;
                push_item($urandom_range(0, 1) ? MODE_READ : MODE_EPOCH, $urandom_range(0, 15),
                          0, 0, 1);
                gen_sample(2, 1'b0);
                made += 5;
            end else if (r < 97) begin
                n = $urandom_range(1, 8);
                gen_sample(n, 1'b1);
                made += n;
            end else begin
                push_item(MODE_NOP, $urandom, $urandom, $urandom_range(0, 1),
                          $urandom_range(0, 1));
            end
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, t_u64 data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[COEF_W-1:0];
        coef[idx]    = data & Q31_MAX;
    endtask

    task automatic cfg_all(t_u64 a, t_u64 b1, t_u64 b2, t_u64 e, t_u64 l, t_u64 c);
        cfg_write(CFG_STEP, a);
        cfg_write(CFG_BETA1, b1);
        cfg_write(CFG_BETA2, b2);
        cfg_write(CFG_EPS, e);
        cfg_write(CFG_LAMBDA, l);
        cfg_write(CFG_L2, c);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for every transaction and result, then for the trailing updates
    task automatic drain();
        while (stim_q.size() != 0 || n_taken != n_loaded || pred_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    function automatic t_u64 rand_coef();
        return $urandom_range(0, 1 << 30);
    endfunction

    // Input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (n_taken == n_loaded) begin
            if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                cur_item         = stim_q.pop_front();
                i_mode          <= cur_item.mode;
                i_feature_index <= cur_item.idx;
                i_feature_value <= cur_item.val;
                i_label_bit     <= cur_item.label;
                i_sample_last   <= cur_item.last;
                i_in_valid      <= 1'b1;
                n_loaded++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Predict on each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            n_taken++;
            train_step(cur_item);
        end
    end

    // Result back-pressure
    always @(negedge i_clk) begin
        calm = (cycle >= 40000 && cycle < 100000);
        i_out_stall <= !calm && ($urandom_range(0, 99) < 17);
    end

    // Result monitor and run limit
    always @(posedge i_clk) begin
        t_pred_res want;
        cycle++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pred_q.size() == 0) begin
                $error("unexpected result value %0d", o_result_value);
                n_errors++;
            end else begin
                want = pred_q.pop_front();
                if (o_result_value !== want.value) begin
                    $error("result_value expected %0d actual %0d", want.value, o_result_value);
                    n_errors++;
                end
                if (o_overflow_flag !== want.ovf) begin
                    $error("overflow_flag expected %0d actual %0d", want.ovf, o_overflow_flag);
                    n_errors++;
                end
            end
        end
        if (cycle >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        coef[CFG_STEP]   = RST_STEP;
        coef[CFG_BETA1]  = RST_BETA1;
        coef[CFG_BETA2]  = RST_BETA2;
        coef[CFG_EPS]    = RST_EPS;
        coef[CFG_LAMBDA] = RST_LAMBDA;
        coef[CFG_L2]     = RST_L2;
        for (int i = 0; i < NUM_FEAT; i++) begin
            weight_mem[i] = 0;
            mom1_mem[i]   = 0;
            mom2_mem[i]   = 0;
        end
        buf_cnt = 0;
        buf_ovf = 1'b0;
        lam_pow = Q30_ONE;
        b1_pow  = Q30_ONE;
        b2_pow  = Q30_ONE;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the memory clear after reset is done
        repeat (2) @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);

        // Directed: field extremes and the named corner cases, reset settings
        push_item(MODE_READ, 0, 0, 0, 0);
        push_item(MODE_READ, NUM_FEAT - 1, -1, 1, 1);
        push_item(MODE_FEAT, 0, 32'sh7FFF_FFFF, 1, 1);
        push_item(MODE_FEAT, NUM_FEAT - 1, 0, 0, 0);
        push_item(MODE_FEAT, NUM_FEAT - 1, 32'sh8000_0000, 0, 1);
        push_item(MODE_FEAT, 5, 1 << 24, 0, 0);
        push_item(MODE_FEAT, 5, -(1 << 23), 1, 1);
        push_item(MODE_FEAT, 0, 0, 1, 1);
        push_item(MODE_FEAT, 7, 3 << 22, 0, 0);
        push_item(MODE_EPOCH, 0, 0, 0, 0);
        push_item(MODE_READ, 5, 0, 0, 0);
        push_item(MODE_FEAT, 8, -(1 << 24), 1, 1);
        push_item(MODE_NOP, NUM_FEAT - 1, -1, 1, 1);
        push_item(MODE_EPOCH, NUM_FEAT - 1, -1, 1, 1);
        push_item(MODE_FEAT, 0, 1, 0, 1);
        push_item(MODE_READ, 0, 0, 0, 0);
        push_item(MODE_READ, 5, 0, 0, 0);
        push_item(MODE_READ, NUM_FEAT - 1, 0, 0, 0);
        gen_random(60, 1'b0);
        drain();

        // Upper extremes: every coefficient at one
        cfg_all(Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE);
        gen_random(80, 1'b1);
        drain();

        // Lower extremes
        cfg_all(0, 0, 0, 0, 0, 0);
        gen_random(60, 1'b0);
        drain();

        // Typical training settings
        cfg_all(1 << 24, 1 << 27, 1 << 20, 1, (1 << 30) - 64, 1 << 16);
        gen_random(100, 1'b1);
        drain();

        cfg_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        gen_random(80, 1'b0);
        drain();

        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[adam_logistic_regression_trainer_top.f]
sv/adamlr_pkg.sv
sv/adamlr_ram.sv
sv/adam_logistic_regression_trainer_top.sv
sv/adamlr_checker.sv
tb/sv/tb_adam_logistic_regression_trainer_top.sv
